// ===== design/four_wheel_encoder_odometry_assert.svh =====
// Assertion macros used by the odometry checker.
`ifndef FOUR_WHEEL_ENCODER_ODOMETRY_ASSERT_SVH
`define FOUR_WHEEL_ENCODER_ODOMETRY_ASSERT_SVH

// Same-cycle implication.
`define FWEO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FWEO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fweo_pkg.sv =====
// Types, constants and helper functions for the wheel odometry block.
package fweo_pkg;

    localparam int ENC_FIELD_W   = 15;
    localparam int ENC_BITS_DEF  = 15;
    localparam int DW            = 88;
    localparam int MUL_STEPS     = 32;
    localparam int CORDIC_STEPS  = 30;

    localparam logic [25:0] PI_Q24      = 26'd52707179;
    localparam logic [13:0] USEC_SCALE  = 14'd15625;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [23:0] MIN_US      = 24'd100;
    localparam logic [15:0] CPR_RST     = 16'd150;
    localparam logic [19:0] RAD_RST     = 20'd8847;
    localparam logic [19:0] DIST_RST    = 20'd34079;

    typedef enum logic [1:0] {
        CFG_COUNTS_PER_REV = 2'd0,
        CFG_WHEEL_RADIUS   = 2'd1,
        CFG_WHEEL_DISTANCE = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic [ENC_FIELD_W-1:0] enc_left_rear;
        logic [ENC_FIELD_W-1:0] enc_right_rear;
        logic [ENC_FIELD_W-1:0] enc_left_front;
        logic [ENC_FIELD_W-1:0] enc_right_front;
        logic [23:0]            elapsed_us;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
        logic [30:0]        angle_left_rear;
        logic [30:0]        angle_right_rear;
        logic [30:0]        angle_left_front;
        logic [30:0]        angle_right_front;
    } result_t;

    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // Signed 32-bit result from a magnitude and a sign, saturating.
    function automatic logic [31:0] sat_mag(input logic [DW-1:0] m, input logic neg);
        logic [31:0] v;
        if (neg) begin
            if (|m[DW-1:31])
                v = 32'h80000000;
            else
                v = 32'd0 - m[31:0];
        end
        else begin
            if (|m[DW-1:31])
                v = 32'h7FFFFFFF;
            else
                v = m[31:0];
        end
        return v;
    endfunction

    function automatic logic [30:0] sat_angle(input logic [DW-1:0] m);
        return (|m[DW-1:31]) ? 31'h7FFFFFFF : m[30:0];
    endfunction

endpackage

// ===== design/fweo_alu.sv =====
// Shared serial multiply / restoring divide unit built around one wide adder.
module fweo_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fweo_pkg::alu_req_t         req,
    input  logic [fweo_pkg::DW-1:0]    opa,
    input  logic [63:0]                opb,
    output logic                       done,
    output logic [fweo_pkg::DW-1:0]    res
);

    localparam int DW = fweo_pkg::DW;
    localparam int CW = $clog2(DW + 1);

    logic                busy_reg;
    logic                done_reg;
    fweo_pkg::alu_op_t   op_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DW-1:0]       acc_reg;
    logic [DW-1:0]       a_reg;
    logic [63:0]         b_reg;
    logic [63:0]         rem_reg;

    logic [63:0]         rem_sh;
    logic                is_div;
    logic [DW-1:0]       x;
    logic [DW-1:0]       y;
    logic [DW:0]         sum;
    logic                ge;

    always_comb
    begin
        is_div = (op_reg == fweo_pkg::ALU_DIV);
        rem_sh = {rem_reg[62:0], acc_reg[DW-1]};
        x      = is_div ? DW'(rem_sh) : acc_reg;
        y      = is_div ? DW'(b_reg) : a_reg;
        sum    = {1'b0, x} + {1'b0, (is_div ? ~y : y)} + (DW+1)'(is_div);
        ge     = sum[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= fweo_pkg::ALU_MUL;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == fweo_pkg::ALU_DIV) ? CW'(DW) : CW'(fweo_pkg::MUL_STEPS);
                acc_reg  <= (req.op == fweo_pkg::ALU_DIV) ? opa : '0;
                a_reg    <= opa;
                b_reg    <= opb;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (is_div)
                begin
                    rem_reg <= ge ? sum[63:0] : rem_sh;
                    acc_reg <= {acc_reg[DW-2:0], ge};
                end
                else
                begin
                    if (b_reg[0])
                        acc_reg <= sum[DW-1:0];
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

// ===== design/four_wheel_encoder_odometry.sv =====
// Top level: four-wheel encoder odometry with a serial arithmetic sequencer.
//
// Usage:
//  - sample channel (sample_valid / sample_stall / sample) takes one word of
//    four raw encoder counts and the elapsed microseconds.
//  - result channel (result_valid / result_stall / result) gives one word per
//    sample: pose, heading, linear and angular rate, four wheel angles.
//  - cfg_we / cfg_index / cfg_data write counts per revolution, wheel radius
//    and wheel spacing; write only while no sample is in work.
//  - Each sample runs 15 serial multiplies and 8 restoring divides, all on
//    one shared adder, and a 30-step CORDIC. sample_stall stays high from
//    acceptance to result, so one sample is in work at a time.
//  - The result register holds its word while result_stall is high; a new
//    sample is still taken meanwhile, and its result waits for the register.
//  - Reset clears the pose, heading and stored encoder counts and loads the
//    default configuration; the first sample after reset gives zero motion.
module four_wheel_encoder_odometry #(
    parameter int ENC_BITS = fweo_pkg::ENC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  fweo_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output fweo_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data
);

    localparam int DW = fweo_pkg::DW;
    localparam int SW = ENC_BITS + 4;
    localparam logic [ENC_BITS+1:0] SPAN    = (ENC_BITS+2)'(1) << ENC_BITS;
    localparam logic [ENC_BITS-1:0] WRAP_LO = ENC_BITS'(150);
    localparam logic [ENC_BITS-1:0] WRAP_HI = ENC_BITS'((1 << ENC_BITS) - 108);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CORDIC, S_FIN} state_t;

    typedef enum logic [4:0] {
        ST_AR, ST_P1, ST_AVG, ST_T1, ST_CU, ST_LIN, ST_BR, ST_CD, ST_DTH, ST_P2,
        ST_T2, ST_CDU, ST_ANG, ST_COS, ST_PX, ST_PY, ST_W0P, ST_W0D, ST_W1P,
        ST_W1D, ST_W2P, ST_W2D, ST_W3P, ST_W3D
    } step_t;

    // control and architectural state
    state_t             state_reg;
    step_t              step_reg;
    logic               result_valid_reg;
    logic [15:0]        cpr_reg;
    logic [19:0]        rad_reg;
    logic [19:0]        dist_reg;
    logic [ENC_BITS-1:0] prev_reg [4];
    logic               have_prev_reg;
    logic signed [31:0] accx_reg;
    logic signed [31:0] accy_reg;
    logic [31:0]        acch_reg;
    logic [4:0]         iter_reg;

    // datapath
    logic [ENC_BITS-1:0] cur_reg [4];
    logic [SW-1:0]      amag_reg;
    logic [SW-1:0]      bmag_reg;
    logic               aneg_reg;
    logic               bpos_reg;
    logic [23:0]        us_reg;
    logic [DW-1:0]      t0_reg;
    logic [DW-1:0]      t1_reg;
    logic [47:0]        avg_reg;
    logic [31:0]        lin_reg;
    logic [31:0]        dth_reg;
    logic [31:0]        ang_reg;
    logic [79:0]        px_reg;
    logic [79:0]        py_reg;
    logic [30:0]        wang_reg [4];
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic               flip_reg;
    fweo_pkg::result_t  result_reg;

    logic [ENC_BITS-1:0] cur [4];
    logic signed [ENC_BITS+1:0] dlt [4];
    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] sb;
    logic [23:0]        us_clamp;
    logic [15:0]        cpr_eff;
    logic [19:0]        dist_eff;
    logic               accept;

    logic               is_div;
    logic [DW-1:0]      num;
    logic [63:0]        dvs;
    logic [DW-1:0]      opa;
    fweo_pkg::alu_req_t alu_req;
    logic               alu_done;
    logic [DW-1:0]      alu_res;

    logic signed [33:0] z_in;
    logic signed [33:0] z_init;
    logic               flip_init;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic signed [33:0] cs_full;
    logic signed [33:0] sn_full;
    logic [31:0]        cs_abs;
    logic [31:0]        sn_abs;
    logic [79:0]        rx;
    logic [79:0]        ry;
    logic [31:0]        newx;
    logic [31:0]        newy;
    logic               out_free;

    function automatic logic [31:0] pose_add(input logic signed [31:0] acc,
                                             input logic [49:0] m, input logic neg);
        logic signed [51:0] s;
        logic signed [51:0] inc;
        logic [31:0]        v;
        inc = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        s   = 52'(acc) + inc;
        if (s > 52'sd2147483647)
            v = 32'h7FFFFFFF;
        else if (s < -52'sd2147483648)
            v = 32'h80000000;
        else
            v = s[31:0];
        return v;
    endfunction

    assign accept   = sample_valid && !sample_stall;
    assign cpr_eff  = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign dist_eff = (dist_reg == 20'd0) ? 20'd1 : dist_reg;
    assign us_clamp = (sample.elapsed_us < fweo_pkg::MIN_US) ? fweo_pkg::MIN_US
                                                             : sample.elapsed_us;

    // wheel deltas with the wrap rule
    always_comb
    begin
        cur[0] = ENC_BITS'(sample.enc_left_rear);
        cur[1] = ENC_BITS'(sample.enc_right_rear);
        cur[2] = ENC_BITS'(sample.enc_left_front);
        cur[3] = ENC_BITS'(sample.enc_right_front);
        for (int w = 0; w < 4; w++)
        begin
            dlt[w] = $signed({2'b00, cur[w]}) - $signed({2'b00, prev_reg[w]});
            if (prev_reg[w] < WRAP_LO && cur[w] > WRAP_HI)
                dlt[w] = dlt[w] - $signed(SPAN);
            else if (prev_reg[w] > WRAP_HI && cur[w] < WRAP_LO)
                dlt[w] = dlt[w] + $signed(SPAN);
            if (!have_prev_reg)
                dlt[w] = '0;
        end
        sa = (SW'(dlt[0]) + SW'(dlt[2])) - (SW'(dlt[1]) + SW'(dlt[3]));
        sb = (SW'(dlt[0]) + SW'(dlt[2])) + (SW'(dlt[1]) + SW'(dlt[3]));
    end

    // CORDIC operands
    always_comb
    begin
        z_in      = 34'($signed(acch_reg));
        z_init    = z_in;
        flip_init = 1'b0;
        if (z_in > 34'sh40000000)
        begin
            z_init    = z_in - 34'sh80000000;
            flip_init = 1'b1;
        end
        else if (z_in < -34'sh40000000)
        begin
            z_init    = z_in + 34'sh80000000;
            flip_init = 1'b1;
        end
        xs      = cx_reg >>> iter_reg;
        ys      = cy_reg >>> iter_reg;
        at      = $signed({4'b0000, fweo_pkg::atan_bam(iter_reg)});
        cs_full = flip_reg ? -cx_reg : cx_reg;
        sn_full = flip_reg ? -cy_reg : cy_reg;
        cs_abs  = cs_full[33] ? 32'(-cs_full) : cs_full[31:0];
        sn_abs  = sn_full[33] ? 32'(-sn_full) : sn_full[31:0];
    end

    // operand selection for the shared unit
    always_comb
    begin
        is_div = 1'b0;
        num    = '0;
        dvs    = '0;
        case (step_reg)
            ST_AR:  begin num = DW'(amag_reg); dvs = 64'(rad_reg); end
            ST_P1:  begin num = t0_reg; dvs = 64'(fweo_pkg::PI_Q24); end
            ST_AVG: begin is_div = 1'b1; num = t0_reg; dvs = 64'(cpr_eff) << 25; end
            ST_T1:  begin num = t0_reg; dvs = 64'(fweo_pkg::USEC_SCALE); end
            ST_CU:  begin num = DW'(us_reg); dvs = 64'(cpr_eff); end
            ST_LIN: begin is_div = 1'b1; num = t0_reg; dvs = t1_reg[63:0] << 19; end
            ST_BR:  begin num = DW'(bmag_reg); dvs = 64'(rad_reg); end
            ST_CD:  begin num = DW'(dist_eff); dvs = 64'(cpr_eff); end
            ST_DTH: begin is_div = 1'b1; num = t0_reg << 31; dvs = t1_reg[63:0]; end
            ST_P2:  begin num = t0_reg; dvs = 64'(fweo_pkg::PI_Q24); end
            ST_T2:  begin num = t0_reg; dvs = 64'(fweo_pkg::USEC_SCALE); end
            ST_CDU: begin num = t1_reg; dvs = 64'(us_reg); end
            ST_ANG: begin is_div = 1'b1; num = t0_reg; dvs = t1_reg[63:0] << 2; end
            ST_PX:  begin num = DW'(avg_reg); dvs = 64'(cs_abs); end
            ST_PY:  begin num = DW'(avg_reg); dvs = 64'(sn_abs); end
            ST_W0P: begin num = DW'(cur_reg[0]); dvs = 64'(fweo_pkg::PI_Q24); end
            ST_W1P: begin num = DW'(cur_reg[1]); dvs = 64'(fweo_pkg::PI_Q24); end
            ST_W2P: begin num = DW'(cur_reg[2]); dvs = 64'(fweo_pkg::PI_Q24); end
            ST_W3P: begin num = DW'(cur_reg[3]); dvs = 64'(fweo_pkg::PI_Q24); end
            ST_W0D, ST_W1D, ST_W2D, ST_W3D:
            begin
                is_div = 1'b1;
                num    = t0_reg;
                dvs    = 64'(cpr_eff) << 7;
            end
            default: begin num = '0; dvs = '0; end
        endcase
        // round the quotient half up
        opa           = is_div ? num + DW'(dvs >> 1) : num;
        alu_req.start = (state_reg == S_ISSUE) && (step_reg != ST_COS);
        alu_req.op    = is_div ? fweo_pkg::ALU_DIV : fweo_pkg::ALU_MUL;
    end

    fweo_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req),
        .opa  (opa),
        .opb  (dvs),
        .done (alu_done),
        .res  (alu_res)
    );

    // pose increments, rounded at 2^-30
    always_comb
    begin
        rx       = px_reg + 80'(32'h20000000);
        ry       = py_reg + 80'(32'h20000000);
        newx     = pose_add(accx_reg, rx[79:30], aneg_reg ^ cs_full[33]);
        newy     = pose_add(accy_reg, ry[79:30], aneg_reg ^ sn_full[33]);
        out_free = !result_valid_reg || !result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= ST_AR;
            result_valid_reg <= 1'b0;
            cpr_reg          <= fweo_pkg::CPR_RST;
            rad_reg          <= fweo_pkg::RAD_RST;
            dist_reg         <= fweo_pkg::DIST_RST;
            for (int w = 0; w < 4; w++)
                prev_reg[w] <= '0;
            have_prev_reg    <= 1'b0;
            accx_reg         <= '0;
            accy_reg         <= '0;
            acch_reg         <= '0;
            iter_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fweo_pkg::CFG_COUNTS_PER_REV: cpr_reg  <= cfg_data[15:0];
                    fweo_pkg::CFG_WHEEL_RADIUS:   rad_reg  <= cfg_data;
                    fweo_pkg::CFG_WHEEL_DISTANCE: dist_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg  <= ST_AR;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    iter_reg  <= '0;
                    state_reg <= (step_reg == ST_COS) ? S_CORDIC : S_WAIT;
                end
                S_WAIT:
                begin
                    if (alu_done)
                    begin
                        if (step_reg == ST_W3D)
                            state_reg <= S_FIN;
                        else
                        begin
                            step_reg  <= step_t'(step_reg + 5'd1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_CORDIC:
                begin
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'(fweo_pkg::CORDIC_STEPS - 1))
                    begin
                        step_reg  <= step_t'(step_reg + 5'd1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_FIN:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        accx_reg         <= newx;
                        accy_reg         <= newy;
                        acch_reg         <= acch_reg + dth_reg;
                        for (int w = 0; w < 4; w++)
                            prev_reg[w] <= cur_reg[w];
                        have_prev_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int w = 0; w < 4; w++)
                cur_reg[w] <= cur[w];
            aneg_reg <= sa[SW-1];
            amag_reg <= sa[SW-1] ? SW'(-sa) : SW'(sa);
            bpos_reg <= !sb[SW-1] && (sb != '0);
            bmag_reg <= sb[SW-1] ? SW'(-sb) : SW'(sb);
            us_reg   <= us_clamp;
        end
        if (state_reg == S_ISSUE && step_reg == ST_COS)
        begin
            cx_reg   <= $signed(fweo_pkg::CORDIC_GAIN);
            cy_reg   <= '0;
            cz_reg   <= z_init;
            flip_reg <= flip_init;
        end
        if (state_reg == S_CORDIC)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
        if (state_reg == S_WAIT && alu_done)
        begin
            case (step_reg)
                ST_AR, ST_P1, ST_T1, ST_BR, ST_P2, ST_T2,
                ST_W0P, ST_W1P, ST_W2P, ST_W3P: t0_reg <= alu_res;
                ST_CU, ST_CD, ST_CDU:           t1_reg <= alu_res;
                ST_AVG: avg_reg <= alu_res[47:0];
                ST_LIN: lin_reg <= fweo_pkg::sat_mag(alu_res, aneg_reg);
                ST_DTH: dth_reg <= bpos_reg ? 32'd0 - alu_res[31:0] : alu_res[31:0];
                ST_ANG: ang_reg <= fweo_pkg::sat_mag(alu_res, bpos_reg);
                ST_PX:  px_reg  <= alu_res[79:0];
                ST_PY:  py_reg  <= alu_res[79:0];
                ST_W0D: wang_reg[0] <= fweo_pkg::sat_angle(alu_res);
                ST_W1D: wang_reg[1] <= fweo_pkg::sat_angle(alu_res);
                ST_W2D: wang_reg[2] <= fweo_pkg::sat_angle(alu_res);
                ST_W3D: wang_reg[3] <= fweo_pkg::sat_angle(alu_res);
                default: ;
            endcase
        end
        if (state_reg == S_FIN && out_free)
        begin
            result_reg.pos_x             <= newx;
            result_reg.pos_y             <= newy;
            result_reg.heading           <= acch_reg + dth_reg;
            result_reg.lin_vel           <= lin_reg;
            result_reg.ang_vel           <= ang_reg;
            result_reg.angle_left_rear   <= wang_reg[0];
            result_reg.angle_right_rear  <= wang_reg[1];
            result_reg.angle_left_front  <= wang_reg[2];
            result_reg.angle_right_front <= wang_reg[3];
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/fweo_checker.sv =====
// Port-level checker for the odometry block, bound to the top level.
`include "four_wheel_encoder_odometry_assert.svh"

module fweo_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input fweo_pkg::result_t result
);

    `FWEO_ASSERT_NXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall, "no stall after sample accept")
    `FWEO_ASSERT_NXT(a_no_instant_result, clk, rst_n, sample_valid && !sample_stall, !$rose(result_valid), "result right after accept")
    `FWEO_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(result_valid), $past(sample_stall), "result without work")
    `FWEO_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind four_wheel_encoder_odometry fweo_checker u_fweo_checker (.*);
